FILE: design/xmr_pkg.sv
// Package for the XMODEM receiver: request and result types, protocol
// characters, result kinds, phase codes and the bytewise CRC-16 step.
// No dependencies.
package xmr_pkg;

  localparam int PacketBytes  = 128;
  localparam int AddrBitsDef  = 24;
  localparam int PollAttempts = 16;
  localparam int QueueDepth   = 8;

  localparam logic [7:0] ChSoh  = 8'h01;
  localparam logic [7:0] ChEot  = 8'h04;
  localparam logic [7:0] ChAck  = 8'h06;
  localparam logic [7:0] ChNak  = 8'h15;
  localparam logic [7:0] ChCan  = 8'h18;
  localparam logic [7:0] ChPoll = 8'h43;

  localparam logic [1:0] OpByte  = 2'd0;
  localparam logic [1:0] OpTick  = 2'd1;
  localparam logic [1:0] OpStart = 2'd2;

  localparam logic [2:0] KindSend    = 3'd0;
  localparam logic [2:0] KindPayload = 3'd1;
  localparam logic [2:0] KindCommit  = 3'd2;
  localparam logic [2:0] KindDiscard = 3'd3;
  localparam logic [2:0] KindEnd     = 3'd4;

  localparam logic [1:0] StComplete  = 2'd0;
  localparam logic [1:0] StCancelled = 2'd1;
  localparam logic [1:0] StNoResp    = 2'd2;
  localparam logic [1:0] StDupLimit  = 2'd3;

  localparam logic [1:0] CfgDestSize  = 2'd0;
  localparam logic [1:0] CfgLongTo    = 2'd1;
  localparam logic [1:0] CfgShortTo   = 2'd2;
  localparam logic [1:0] CfgMaxRetx   = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_POLL   = 4'b0010,
    PH_CAN2   = 4'b0100,
    PH_PACKET = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_C    = 2'd1,
    MODE_NAK  = 2'd2
  } poll_mode_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [23:0] data_address;
    logic [1:0]  end_status;
    logic [23:0] total_length;
    logic        last;
  } out_res_t;

  function automatic out_res_t mk_res(logic [2:0] kind, logic [7:0] b,
                                      logic [23:0] addr, logic [1:0] st,
                                      logic [23:0] len);
    out_res_t r;
    r.kind         = kind;
    r.data_byte    = b;
    r.data_address = addr;
    r.end_status   = st;
    r.total_length = len;
    r.last         = 1'b0;
    return r;
  endfunction

  // CRC-16/XMODEM, poly 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: design/xmodem_receiver_top.sv
// XMODEM receiver top level: session control, packet checks and the
// result queue. Depends on xmr_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------
//  in       | in        | in_valid/in_stall  | in_req_i  (opcode, rx_byte)
//  out      | out       | out_valid/out_stall| out_res_o (one result each)
//  cfg      | in        | cfg_valid/ready    | cfg_index_i, cfg_data_i
//
// Each request is worked in the cycle it is accepted; its zero to four
// results enter an eight-entry result queue at once and leave one a cycle
// while out_stall_i is low. A request can be taken every cycle while the
// queue has room for four results; the queue drain (one result per cycle
// while not stalled) sets the sustained rate when requests produce several
// results. Reset clears the session state, the queue and the registers to
// their defaults. The configuration port is always ready.
module xmodem_receiver_top
  import xmr_pkg::*;
#(
  parameter int ADDR_BITS = AddrBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_res_t    out_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [23:0] AddrMask =
    (ADDR_BITS >= 24) ? 24'hFFFFFF : 24'((64'd1 << ADDR_BITS) - 64'd1);
  localparam int PtrW = $clog2(QueueDepth);

  // Configuration registers
  logic [23:0] dest_size_q;
  logic [31:0] long_to_q, short_to_q;
  logic [4:0]  max_retx_q;

  // Session state
  phase_e      phase_q, phase_d;
  poll_mode_e  mode_q, mode_d;
  logic [4:0]  retry_q, retry_d, rleft_q, rleft_d;
  logic        crc_mode_q, crc_mode_d;
  logic [7:0]  exp_q, exp_d, bidx_q, bidx_d, sum_q, sum_d;
  logic [15:0] bac_q, bac_d, crc_q, crc_d, rchk_q, rchk_d;
  logic [23:0] acc_q, acc_d;
  logic [31:0] timer_q, timer_d;

  // Result queue
  out_res_t          queue_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  out_res_t    res [4];
  logic [2:0]  n;
  logic        in_acc, pop;

  assign in_stall_o  = cnt_q > (PtrW+1)'(QueueDepth - 4);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign out_res_o   = queue_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  logic [4:0] max_eff;
  assign max_eff = (max_retx_q == 5'd0) ? 5'd1 : max_retx_q;

  always_comb begin
    phase_e      ph;
    logic        do_next, do_resume, ok, okc, open;
    logic [31:0] tinc, lim;
    logic [7:0]  b, bnew, blk, cmp;
    logic [24:0] a;
    logic [23:0] room, cnt_b;
    logic [4:0]  rinc;

    phase_d = phase_q;  mode_d = mode_q;  retry_d = retry_q;  rleft_d = rleft_q;
    crc_mode_d = crc_mode_q;  exp_d = exp_q;  bidx_d = bidx_q;  sum_d = sum_q;
    bac_d = bac_q;  crc_d = crc_q;  rchk_d = rchk_q;  acc_d = acc_q;
    timer_d = timer_q;
    n = '0;
    for (int i = 0; i < 4; i++) res[i] = '0;
    do_next = 1'b0;  do_resume = 1'b0;
    b = in_req_i.rx_byte;
    tinc = (timer_q == 32'hFFFFFFFF) ? timer_q : timer_q + 32'd1;
    lim  = '0;  a = '0;  bnew = '0;  blk = '0;  cmp = '0;
    ok = 1'b0;  okc = 1'b0;  open = 1'b0;  room = '0;  cnt_b = '0;  rinc = '0;

    case (phase_q)
      PH_POLL, PH_CAN2, PH_PACKET: ph = phase_q;
      default:                     ph = PH_IDLE;
    endcase

    if (in_acc) begin
      case (in_req_i.opcode)
        OpStart: begin
          if (ph == PH_PACKET && bidx_q != 8'd0 && bac_q[15:8] == exp_q) begin
            res[n[1:0]] = mk_res(KindDiscard, '0, '0, '0, '0);  n = n + 3'd1;
          end
          retry_d = '0;  mode_d = MODE_C;  crc_mode_d = 1'b0;  exp_d = 8'd1;
          rleft_d = max_eff;  bidx_d = '0;  bac_d = '0;  crc_d = '0;  sum_d = '0;
          rchk_d = '0;  acc_d = '0;  phase_d = PH_POLL;  timer_d = '0;
          res[n[1:0]] = mk_res(KindSend, ChPoll, '0, '0, '0);  n = n + 3'd1;
        end
        OpTick: begin
          if (ph != PH_IDLE) begin
            lim = (ph == PH_POLL) ? long_to_q : short_to_q;
            timer_d = tinc;
            if (tinc >= lim) begin
              timer_d = '0;
              if (ph == PH_PACKET) begin
                if (bidx_q != 8'd0 && bac_q[15:8] == exp_q) begin
                  res[n[1:0]] = mk_res(KindDiscard, '0, '0, '0, '0);  n = n + 3'd1;
                end
                res[n[1:0]] = mk_res(KindSend, ChNak, '0, '0, '0);  n = n + 3'd1;
                do_resume = 1'b1;
              end else begin
                do_next = 1'b1;
              end
            end
          end
        end
        OpByte: begin
          case (ph)
            PH_POLL: begin
              if (b == ChSoh) begin
                if (mode_q == MODE_C) crc_mode_d = 1'b1;
                mode_d = MODE_NONE;  phase_d = PH_PACKET;  bidx_d = '0;
                bac_d = '0;  crc_d = '0;  sum_d = '0;  rchk_d = '0;  timer_d = '0;
              end else if (b == ChEot) begin
                res[0] = mk_res(KindSend, ChAck, '0, '0, '0);
                res[1] = mk_res(KindEnd, '0, '0, StComplete, acc_q);
                n = 3'd2;  phase_d = PH_IDLE;
              end else if (b == ChCan) begin
                phase_d = PH_CAN2;  timer_d = '0;
              end else begin
                do_next = 1'b1;
              end
            end
            PH_CAN2: begin
              if (b == ChCan) begin
                res[0] = mk_res(KindSend, ChAck, '0, '0, '0);
                res[1] = mk_res(KindEnd, '0, '0, StCancelled, acc_q);
                n = 3'd2;  phase_d = PH_IDLE;
              end else begin
                do_next = 1'b1;
              end
            end
            PH_PACKET: begin
              timer_d = '0;
              if (bidx_q == 8'd0) begin
                bac_d = {b, 8'h00};
              end else if (bidx_q == 8'd1) begin
                bac_d = {bac_q[15:8], b};
              end else if (bidx_q < 8'(2 + PacketBytes)) begin
                a = {1'b0, acc_q} + 25'(bidx_q - 8'd2);
                sum_d = sum_q + b;
                crc_d = crc_step(crc_q, b);
                if (bac_q[15:8] == exp_q && a < {1'b0, dest_size_q}) begin
                  res[0] = mk_res(KindPayload, b, a[23:0] & AddrMask, '0, '0);
                  n = 3'd1;
                end
              end else begin
                rchk_d = {rchk_q[7:0], b};
              end
              bnew   = bidx_q + 8'd1;
              bidx_d = bnew;
              if (bnew >= 8'(PacketBytes + 3) + {7'd0, crc_mode_q}) begin
                // Packet complete: check it and answer
                blk  = bac_d[15:8];
                cmp  = bac_d[7:0];
                okc  = crc_mode_q ? (rchk_d == crc_q) : (rchk_d[7:0] == sum_q);
                ok   = blk == ~cmp && (blk == exp_q || blk == exp_q - 8'd1) && okc;
                open = blk == exp_q;
                if (!ok) begin
                  if (open) begin
                    res[n[1:0]] = mk_res(KindDiscard, '0, '0, '0, '0);  n = n + 3'd1;
                  end
                  res[n[1:0]] = mk_res(KindSend, ChNak, '0, '0, '0);  n = n + 3'd1;
                  do_resume = 1'b1;
                end else if (blk == exp_q) begin
                  room  = dest_size_q - acc_q;
                  cnt_b = (dest_size_q <= acc_q) ? 24'd0 :
                          (room > 24'(PacketBytes)) ? 24'(PacketBytes) : room;
                  acc_d = acc_q + cnt_b;
                  exp_d = exp_q + 8'd1;
                  rleft_d = max_eff;
                  res[0] = mk_res(KindCommit, '0, '0, '0, '0);
                  res[1] = mk_res(KindSend, ChAck, '0, '0, '0);
                  n = 3'd2;  do_resume = 1'b1;
                end else if (rleft_q <= 5'd1) begin
                  // Too many duplicates: cancel the session
                  rleft_d = '0;
                  res[0] = mk_res(KindSend, ChCan, '0, '0, '0);
                  res[1] = mk_res(KindSend, ChCan, '0, '0, '0);
                  res[2] = mk_res(KindSend, ChCan, '0, '0, '0);
                  res[3] = mk_res(KindEnd, '0, '0, StDupLimit, acc_q);
                  n = 3'd4;  phase_d = PH_IDLE;
                end else begin
                  rleft_d = rleft_q - 5'd1;
                  res[0] = mk_res(KindSend, ChAck, '0, '0, '0);
                  n = 3'd1;  do_resume = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      if (do_resume) begin
        retry_d = '0;  phase_d = PH_POLL;  timer_d = '0;
      end

      if (do_next) begin
        // Next polling attempt: fall back to NAK after the 'C' attempts
        rinc    = retry_q + 5'd1;
        retry_d = rinc;
        if (rinc < 5'(PollAttempts)) begin
          phase_d = PH_POLL;  timer_d = '0;
          if (mode_q == MODE_C) begin
            res[0] = mk_res(KindSend, ChPoll, '0, '0, '0);  n = 3'd1;
          end else if (mode_q == MODE_NAK) begin
            res[0] = mk_res(KindSend, ChNak, '0, '0, '0);  n = 3'd1;
          end
        end else if (mode_q == MODE_C) begin
          mode_d = MODE_NAK;  retry_d = '0;  phase_d = PH_POLL;  timer_d = '0;
          res[0] = mk_res(KindSend, ChNak, '0, '0, '0);  n = 3'd1;
        end else begin
          res[0] = mk_res(KindSend, ChCan, '0, '0, '0);
          res[1] = mk_res(KindSend, ChCan, '0, '0, '0);
          res[2] = mk_res(KindSend, ChCan, '0, '0, '0);
          res[3] = mk_res(KindEnd, '0, '0, StNoResp, acc_q);
          n = 3'd4;  phase_d = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_size_q <= 24'd65536;
      long_to_q   <= 32'd2000;
      short_to_q  <= 32'd1000;
      max_retx_q  <= 5'd25;
      phase_q     <= PH_IDLE;
      mode_q      <= MODE_C;
      retry_q     <= '0;
      rleft_q     <= 5'd25;
      crc_mode_q  <= 1'b0;
      exp_q       <= 8'd1;
      bidx_q      <= '0;
      sum_q       <= '0;
      bac_q       <= '0;
      crc_q       <= '0;
      rchk_q      <= '0;
      acc_q       <= '0;
      timer_q     <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgDestSize: dest_size_q <= cfg_data_i[23:0];
          CfgLongTo:   long_to_q   <= cfg_data_i;
          CfgShortTo:  short_to_q  <= cfg_data_i;
          CfgMaxRetx:  max_retx_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      phase_q    <= phase_d;
      mode_q     <= mode_d;
      retry_q    <= retry_d;
      rleft_q    <= rleft_d;
      crc_mode_q <= crc_mode_d;
      exp_q      <= exp_d;
      bidx_q     <= bidx_d;
      sum_q      <= sum_d;
      bac_q      <= bac_d;
      crc_q      <= crc_d;
      rchk_q     <= rchk_d;
      acc_q      <= acc_d;
      timer_q    <= timer_d;
      wr_q       <= wr_q + PtrW'(n);
      if (pop) rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(n) - (PtrW+1)'(pop);
    end
  end

  // Queue entries: each slot takes the result whose offset from the write
  // pointer matches it; mark the final result of the request.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QueueDepth; j++) begin
      logic [PtrW-1:0] off;
      out_res_t        ent;
      off = PtrW'(j) - wr_q;
      ent = res[off[1:0]];
      ent.last = ({1'b0, off} == (PtrW+1)'(n - 3'd1));
      if ({1'b0, off} < (PtrW+1)'(n)) begin
        queue_q[j] <= ent;
      end
    end
  end

endmodule

FILE: design/xmr_checker.sv
// Port-level checker for the XMODEM receiver, bound to the top level.
// Depends on xmr_pkg.
module xmr_checker
  import xmr_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_res_t out_res_o,
  input logic     cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.kind == KindEnd |-> out_res_o.last)
    else $error("session end is not the last result of its request");

  a_send_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.kind == KindSend |->
      out_res_o.data_address == '0 && out_res_o.total_length == '0 &&
      out_res_o.end_status == '0)
    else $error("send result carries stray fields");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind xmodem_receiver_top xmr_checker u_xmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o),
  .cfg_ready_o (cfg_ready_o)
);

FILE: dv/testbench.sv
// Self-checking testbench for xmodem_receiver_top: drives byte, tick and start
// requests, predicts every result with its own session model and checks them.
// Depends on xmr_pkg and the xmodem_receiver_top RTL.
module testbench;
  import xmr_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam int MaxShown   = 10;
  localparam int DrainGap   = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  out_res_t    out_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CfgDestSize;
  logic [31:0] cfg_data = '0;

  xmodem_receiver_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Idling knobs for the request driver and the result receiver, and run counters.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned n_reqs      = 0;
  int unsigned n_errors    = 0;
  int unsigned n_cycles    = 0;

  // ---------------------------------------------------------------------------
  // Session model: registers, state and the results each request causes.
  // ---------------------------------------------------------------------------
  logic [23:0] r_dest;
  logic [31:0] r_long_to, r_short_to;
  logic [4:0]  r_max_retx;

  phase_e      s_phase;
  logic [4:0]  s_retry;
  poll_mode_e  s_mode;
  logic        s_crc_mode;
  logic [7:0]  s_exp_blk;
  logic [4:0]  s_retx_left;
  logic [7:0]  s_idx;
  logic [15:0] s_blk_cmp, s_crc, s_rx_check;
  logic [7:0]  s_sum;
  logic [23:0] s_accepted;
  logic [31:0] s_timer;

  out_res_t    step_res[$];
  out_res_t    pending_res[$];

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
    end
    return v;
  endfunction

  function void push_res(logic [2:0] k, logic [7:0] b, logic [23:0] a,
                         logic [1:0] st, logic [23:0] len);
    out_res_t r;
    // At most four results per request; further ones are dropped.
    if (step_res.size() < 4) begin
      r.kind = k; r.data_byte = b; r.data_address = a;
      r.end_status = st; r.total_length = len; r.last = 1'b0;
      step_res.push_back(r);
    end
  endfunction

  function void tx_char(logic [7:0] b);
    push_res(KindSend, b, '0, StComplete, '0);
  endfunction

  function void close_session(logic [1:0] st);
    push_res(KindEnd, '0, '0, st, s_accepted);
    s_phase = PH_IDLE;
  endfunction

  function void cancel_session(logic [1:0] st);
    tx_char(ChCan); tx_char(ChCan); tx_char(ChCan);
    close_session(st);
  endfunction

  function logic [4:0] retx_limit();
    return (r_max_retx == 0) ? 5'd1 : r_max_retx;
  endfunction

  function bit pkt_open();
    return s_idx >= 1 && s_blk_cmp[15:8] == s_exp_blk;
  endfunction

  function void poll_again();
    s_phase = PH_POLL;
    s_timer = '0;
    if (s_mode == MODE_C) tx_char(ChPoll);
    else if (s_mode == MODE_NAK) tx_char(ChNak);
  endfunction

  function void next_attempt();
    s_retry++;
    if (s_retry < PollAttempts) begin
      poll_again();
    end else if (s_mode == MODE_C) begin
      // C polling exhausted: drop to NAK, which also selects the checksum
      s_mode = MODE_NAK;
      s_retry = '0;
      poll_again();
    end else begin
      cancel_session(StNoResp);
    end
  endfunction

  function void resume_polling();
    s_retry = '0;
    s_phase = PH_POLL;
    s_timer = '0;
  endfunction

  function void finish_packet();
    logic [7:0]  blk, cmp;
    logic [23:0] room;
    bit          chk_ok, ok;
    blk = s_blk_cmp[15:8];
    cmp = s_blk_cmp[7:0];
    chk_ok = s_crc_mode ? (s_rx_check == s_crc) : (s_rx_check[7:0] == s_sum);
    ok = (blk == ~cmp) && (blk == s_exp_blk || blk == s_exp_blk - 8'd1) && chk_ok;
    if (!ok) begin
      if (pkt_open()) push_res(KindDiscard, '0, '0, StComplete, '0);
      tx_char(ChNak);
      resume_polling();
    end else if (blk == s_exp_blk) begin
      room = '0;
      if (r_dest > s_accepted) begin
        room = r_dest - s_accepted;
        if (room > 24'(PacketBytes)) room = 24'(PacketBytes);
      end
      s_accepted = s_accepted + room;
      push_res(KindCommit, '0, '0, StComplete, '0);
      s_exp_blk++;
      s_retx_left = retx_limit();
      tx_char(ChAck);
      resume_polling();
    end else if (s_retx_left <= 1) begin
      // duplicate with no retransmits left
      s_retx_left = '0;
      cancel_session(StDupLimit);
    end else begin
      s_retx_left--;
      tx_char(ChAck);
      resume_polling();
    end
  endfunction

  function void take_pkt_byte(logic [7:0] b);
    logic [31:0] addr;
    int          total;
    total = PacketBytes + 3 + s_crc_mode;
    s_timer = '0;
    if (s_idx == 0) begin
      s_blk_cmp = {b, 8'h00};
    end else if (s_idx == 1) begin
      s_blk_cmp[7:0] = b;
    end else if (s_idx < 2 + PacketBytes) begin
      addr = {8'h00, s_accepted} + s_idx - 2;
      s_sum = s_sum + b;
      s_crc = crc16_byte(s_crc, b);
      if (pkt_open() && addr < {8'h00, r_dest})
        push_res(KindPayload, b, addr[23:0], StComplete, '0);
    end else begin
      s_rx_check = {s_rx_check[7:0], b};
    end
    s_idx++;
    if (s_idx >= total) finish_packet();
  endfunction

  function void begin_session();
    s_retry = '0; s_mode = MODE_C; s_crc_mode = 1'b0; s_exp_blk = 8'd1;
    s_retx_left = retx_limit(); s_idx = '0; s_blk_cmp = '0; s_crc = '0;
    s_sum = '0; s_rx_check = '0; s_accepted = '0;
    poll_again();
  endfunction

  function void reset_session_model();
    r_dest = 24'd65536; r_long_to = 32'd2000; r_short_to = 32'd1000;
    r_max_retx = 5'd25;
    s_phase = PH_IDLE; s_retry = '0; s_mode = MODE_C; s_crc_mode = 1'b0;
    s_exp_blk = 8'd1; s_retx_left = 5'd25; s_idx = '0; s_blk_cmp = '0;
    s_crc = '0; s_sum = '0; s_rx_check = '0; s_accepted = '0; s_timer = '0;
  endfunction

  // Work out the results of one accepted request and queue them.
  function void predict_results(in_req_t rq);
    logic [31:0] lim;
    step_res.delete();
    if (rq.opcode == OpStart) begin
      if (s_phase == PH_PACKET && pkt_open())
        push_res(KindDiscard, '0, '0, StComplete, '0);
      begin_session();
    end else if (rq.opcode == OpTick) begin
      if (s_phase != PH_IDLE) begin
        lim = (s_phase == PH_POLL) ? r_long_to : r_short_to;
        if (s_timer != 32'hFFFF_FFFF) s_timer++;
        if (s_timer >= lim) begin
          s_timer = '0;
          if (s_phase == PH_PACKET) begin
            if (pkt_open()) push_res(KindDiscard, '0, '0, StComplete, '0);
            tx_char(ChNak);
            resume_polling();
          end else begin
            next_attempt();
          end
        end
      end
    end else if (rq.opcode == OpByte) begin
      if (s_phase == PH_POLL) begin
        if (rq.rx_byte == ChSoh) begin
          if (s_mode == MODE_C) s_crc_mode = 1'b1;
          s_mode = MODE_NONE;
          s_phase = PH_PACKET;
          s_idx = '0; s_blk_cmp = '0; s_crc = '0; s_sum = '0;
          s_rx_check = '0; s_timer = '0;
        end else if (rq.rx_byte == ChEot) begin
          tx_char(ChAck);
          close_session(StComplete);
        end else if (rq.rx_byte == ChCan) begin
          s_phase = PH_CAN2;
          s_timer = '0;
        end else begin
          next_attempt();
        end
      end else if (s_phase == PH_CAN2) begin
        if (rq.rx_byte == ChCan) begin
          tx_char(ChAck);
          close_session(StCancelled);
        end else begin
          next_attempt();
        end
      end else if (s_phase == PH_PACKET) begin
        take_pkt_byte(rq.rx_byte);
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) pending_res.push_back(step_res[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result receiver: random stall, long hold-offs on demand.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxShown)
          $display("unexpected result kind=%0d byte=%h", out_res.kind, out_res.data_byte);
      end else begin
        want = pending_res.pop_front();
        if (want.kind != out_res.kind || want.data_byte != out_res.data_byte ||
            want.data_address != out_res.data_address ||
            want.end_status != out_res.end_status ||
            want.total_length != out_res.total_length || want.last != out_res.last) begin
          n_errors++;
          if (n_errors <= MaxShown)
            $display("mismatch: exp kind=%0d byte=%h addr=%h st=%0d len=%0d last=%0b / got kind=%0d byte=%h addr=%h st=%0d len=%0d last=%0b",
                     want.kind, want.data_byte, want.data_address, want.end_status,
                     want.total_length, want.last, out_res.kind, out_res.data_byte,
                     out_res.data_address, out_res.end_status, out_res.total_length,
                     out_res.last);
        end
      end
    end
  end

  // Watchdog: fail and end the run once the cycle count passes CycleLimit.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("** xmodem_receiver_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. Called at a falling edge, returns at a falling edge with
  // valid still high so that back-to-back requests never lower it.
  // ---------------------------------------------------------------------------
  task automatic put_req(logic [1:0] op, logic [7:0] b);
    in_req_t rq;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    rq.opcode = op;
    rq.rx_byte = b;
    in_valid <= 1'b1;
    in_req <= rq;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_results(rq);
    n_reqs++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (DrainGap) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CfgDestSize: r_dest = val[23:0];
      CfgLongTo:   r_long_to = val;
      CfgShortTo:  r_short_to = val;
      default:     r_max_retx = val[4:0];
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Send one packet; corrupt the complement or check, or cut it short and let
  // it time out. The check follows the mode the SOH selected.
  task automatic send_packet(logic [7:0] blk, bit bad_cmp, bit bad_chk, int cut);
    logic [7:0]  data;
    logic [15:0] crc;
    logic [7:0]  sum;
    int          sent;
    crc = '0; sum = '0; sent = 0;
    put_req(OpByte, ChSoh);
    put_req(OpByte, blk);
    put_req(OpByte, bad_cmp ? blk : ~blk);
    for (int i = 0; i < PacketBytes; i++) begin
      if (cut > 0 && i >= PacketBytes - cut) break;
      data = 8'($urandom);
      crc = crc16_byte(crc, data);
      sum = sum + data;
      put_req(OpByte, data);
      sent++;
    end
    if (sent < PacketBytes) begin
      // truncated: tick until the short timeout expires
      for (int t = 0; t < 40 && s_phase == PH_PACKET; t++) put_req(OpTick, '0);
    end else if (s_crc_mode) begin
      if (bad_chk) crc = crc ^ 16'h0100;
      put_req(OpByte, crc[15:8]);
      put_req(OpByte, crc[7:0]);
    end else begin
      put_req(OpByte, bad_chk ? sum + 8'd1 : sum);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_idle_and_control();
    put_req(OpByte, 8'hFF);          // ignored while idle
    put_req(OpTick, '0);
    put_req(2'd3, 8'hAA);            // unused opcode
    put_req(OpStart, '0);
    put_req(OpByte, ChEot);          // complete, nothing accepted
    put_req(OpStart, '0);
    put_req(OpByte, ChCan);
    put_req(OpByte, ChCan);          // sender cancelled
    put_req(OpStart, '0);
    put_req(OpByte, ChCan);
    put_req(OpByte, 8'h55);          // lone CAN costs one attempt
    put_req(OpByte, 8'h00);
    put_req(OpStart, '0);            // restart while polling
    put_req(OpByte, ChSoh);
    put_req(OpByte, 8'h01);
    put_req(OpByte, 8'hFE);
    put_req(OpByte, 8'h5A);
    put_req(OpStart, '0);            // restart with an open packet
    put_req(OpByte, ChEot);
    wait_drained();
  endtask

  task automatic test_poll_exhaustion();
    write_reg(CfgLongTo, 32'd1);
    put_req(OpStart, '0);
    // 16 C polls, 16 NAK polls, then CAN x3 with no-response status
    for (int i = 0; i < 2 * PollAttempts; i++) put_req(OpTick, '0);
    write_reg(CfgLongTo, 32'hFFFF_FFFF);
    put_req(OpStart, '0);
    repeat (4) put_req(OpTick, '0);
    put_req(OpByte, ChEot);
    wait_drained();
  endtask

  task automatic test_crc_packets();
    write_reg(CfgShortTo, 32'd3);
    write_reg(CfgDestSize, 32'd200);
    put_req(OpStart, '0);
    send_packet(8'd1, 1'b0, 1'b0, 0);      // commit, all bytes kept
    send_packet(8'd1, 1'b0, 1'b0, 0);      // duplicate, acknowledged
    send_packet(8'd2, 1'b1, 1'b0, 0);      // bad complement
    send_packet(8'd2, 1'b0, 1'b1, 0);      // bad CRC, discarded
    send_packet(8'd2, 1'b0, 1'b0, 0);      // capacity reached part way
    send_packet(8'd3, 1'b0, 1'b0, 100);    // times out mid-packet
    send_packet(8'd9, 1'b0, 1'b0, 0);      // wrong block
    put_req(OpByte, ChEot);
    wait_drained();
  endtask

  task automatic test_checksum_and_capacity();
    write_reg(CfgLongTo, 32'd1);
    write_reg(CfgDestSize, 32'd0);
    put_req(OpStart, '0);
    for (int i = 0; i < PollAttempts; i++) put_req(OpTick, '0);
    send_packet(8'd1, 1'b0, 1'b0, 0);      // checksum mode, nothing fits
    write_reg(CfgDestSize, 32'hFF_FFFF);
    put_req(OpStart, '0);
    for (int i = 0; i < PollAttempts; i++) put_req(OpTick, '0);
    send_packet(8'd1, 1'b0, 1'b1, 0);      // bad checksum
    send_packet(8'd1, 1'b0, 1'b0, 0);
    put_req(OpByte, ChEot);
    wait_drained();
  endtask

  task automatic test_duplicate_abort();
    write_reg(CfgMaxRetx, 32'd1);
    put_req(OpStart, '0);
    send_packet(8'd1, 1'b0, 1'b0, 0);
    send_packet(8'd1, 1'b0, 1'b0, 0);      // one duplicate is too many
    write_reg(CfgMaxRetx, 32'd0);          // zero counts as one
    put_req(OpStart, '0);
    send_packet(8'd1, 1'b0, 1'b0, 0);
    send_packet(8'd1, 1'b0, 1'b0, 0);
    write_reg(CfgMaxRetx, 32'd31);
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_reg(CfgDestSize, 32'd65536);
    put_req(OpStart, '0);
    // hold the receiver off while requests keep coming; the queue must fill
    hold_cycles = 400;
    send_packet(8'd1, 1'b0, 1'b0, 0);
    wait_drained();                  // sender pauses until all results are in
    put_req(OpByte, ChEot);
    wait_drained();
  endtask

  task automatic random_session(int n_pkts);
    int unsigned pick;
    put_req(OpStart, '0);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 6)) put_req(2'($urandom_range(0, 3)), 8'($urandom));
    for (int p = 0; p < n_pkts && s_phase != PH_IDLE; p++) begin
      if (s_phase != PH_POLL) break;
      pick = $urandom_range(99);
      if (pick < 60) send_packet(s_exp_blk, 1'b0, 1'b0, 0);
      else if (pick < 70) send_packet(s_exp_blk - 8'd1, 1'b0, 1'b0, 0);
      else if (pick < 78) send_packet(s_exp_blk, 1'b0, 1'b1, 0);
      else if (pick < 84) send_packet(s_exp_blk, 1'b1, 1'b0, 0);
      else if (pick < 90) send_packet(s_exp_blk, 1'b0, 1'b0, $urandom_range(1, 127));
      else if (pick < 95) send_packet(8'($urandom), 1'($urandom_range(1)), 1'b0, 0);
      else repeat ($urandom_range(1, 4)) put_req(2'($urandom_range(0, 3)), 8'($urandom));
    end
    pick = $urandom_range(3);
    if (pick == 0) begin
      put_req(OpByte, ChCan);
      put_req(OpByte, ChCan);
    end else if (pick == 1) begin
      put_req(OpByte, ChCan);
      put_req(OpByte, 8'($urandom));
    end
    put_req(OpByte, ChEot);
    put_req(OpByte, ChEot);
  endtask

  task automatic test_random();
    int unsigned goal;
    write_reg(CfgLongTo, 32'd4);
    write_reg(CfgShortTo, 32'd2);
    write_reg(CfgMaxRetx, 32'd2);
    write_reg(CfgDestSize, $urandom_range(0, 600));
    goal = n_reqs + 250;
    while (n_reqs < goal) random_session($urandom_range(1, 2));
    wait_drained();
  endtask

  initial begin
    reset_session_model();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 23; rx_idle_pct = 85;
    test_idle_and_control();
    test_poll_exhaustion();
    test_crc_packets();
    test_random();

    tx_idle_pct = 85; rx_idle_pct = 23;
    test_checksum_and_capacity();
    test_duplicate_abort();
    test_random();

    tx_idle_pct = 0; rx_idle_pct = 0;
    test_backpressure();
    test_random();

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (n_errors == 0 && pending_res.size() == 0) begin
      $display("** xmodem_receiver_top: PASSED **");
    end else begin
      $display("** xmodem_receiver_top: FAILED **");
    end
    $finish;
  end

endmodule
